// File: src/sprite_xor_framebuffer_assert.svh
// Assertion macros for the checker of the sprite frame store.
`ifndef SPRITE_XOR_FRAMEBUFFER_ASSERT_SVH
`define SPRITE_XOR_FRAMEBUFFER_ASSERT_SVH

// Same-cycle implication, sampled on aclk and switched off while aresetn is low.
`define SXFB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sprite_xor_framebuffer: assertion failed");

// Next-cycle implication, sampled on aclk and switched off while aresetn is low.
`define SXFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sprite_xor_framebuffer: assertion failed");

`endif

// File: src/sxfb_pkg.sv
// Shared constants of the sprite XOR frame store: operation codes, sizes and beat widths.
package sxfb_pkg;

    localparam int ROW_BYTES_DEFAULT   = 8;
    localparam int SCREEN_ROWS_DEFAULT = 32;
    localparam int PIX_PER_BYTE        = 8;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    typedef logic [1:0] op_t;

    localparam op_t OP_CLEAR = 2'd0;
    localparam op_t OP_DRAW  = 2'd1;
    localparam op_t OP_READ  = 2'd2;
    localparam op_t OP_ACK   = 2'd3;

endpackage

// File: src/sprite_xor_framebuffer.sv
// Monochrome frame store with XOR sprite-row drawing, collision detection and byte read-out.
//
// The block holds a frame of ROW_BYTES*8 by SCREEN_ROWS pixels, packed eight pixels to a byte
// with the most significant bit as the leftmost pixel, in one single-port-write memory with a
// registered read. Each input beat carries one operation and produces exactly one result beat.
// A sprite-row draw does a read-modify-write of two store bytes through the one memory read
// port, after coordinate wrapping (reciprocal multiply, remainder, row times row-length).
// A clear and the pass that follows reset both write zero to one byte per cycle, so after
// aresetn is released no beat is taken until the store is clear. The result beat sits in an
// output register, so a new input beat is taken while an earlier result still waits for
// m_tready; the block only holds off when a finished result has nowhere to go. The column is
// taken modulo the screen width and the drawn row, y plus the sprite row index, modulo
// SCREEN_ROWS; the second byte of a straddling sprite wraps to column byte 0 of the same row.
// A row index of zero restarts the collision flag before that row is drawn, and a pixel
// collides when it is lit both in the store and in the sprite bits drawn over it. The tlast
// mark on the input carries the last-row flag of a sprite; it changes nothing, since every
// result beat already reports the collision flag so far.
module sprite_xor_framebuffer #(
    parameter int ROW_BYTES   = sxfb_pkg::ROW_BYTES_DEFAULT,
    parameter int SCREEN_ROWS = sxfb_pkg::SCREEN_ROWS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // From bit 0 up: x[7:0], y[15:8], sprite_row_index[19:16], sprite_byte[27:20],
    // read_address[35:28], zero padding[39:36].
    input  logic [sxfb_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[1:0].
    input  logic [sxfb_pkg::S_TUSER_W-1:0] s_tuser,
    // last_row.
    input  logic                           s_tlast,
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // From bit 0 up: read_data[7:0], collision[8], redraw_pending[9], zero padding[15:10].
    output logic [sxfb_pkg::M_TDATA_W-1:0] m_tdata
);

    // Geometry and index widths.
    localparam int STORE_SIZE   = ROW_BYTES * SCREEN_ROWS;
    localparam int SCREEN_WIDTH = ROW_BYTES * sxfb_pkg::PIX_PER_BYTE;
    localparam int AW  = (STORE_SIZE > 1)  ? $clog2(STORE_SIZE)  : 1;
    localparam int CW  = (ROW_BYTES > 1)   ? $clog2(ROW_BYTES)   : 1;
    localparam int RW  = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int PXW = CW + 3;
    localparam int BW  = RW + 5;

    // Rounded-up reciprocals: with these shifts the quotient is exact over the input ranges.
    localparam logic [16:0] RECIP_X = 17'((2**16 + SCREEN_WIDTH - 1) / SCREEN_WIDTH);
    localparam logic [17:0] RECIP_Y = 18'((2**17 + SCREEN_ROWS - 1) / SCREEN_ROWS);
    localparam logic [18:0] RECIP_A = 19'((2**18 + STORE_SIZE - 1) / STORE_SIZE);

    localparam logic [7:0]    WIDTH_K  = 8'(SCREEN_WIDTH);
    localparam logic [6:0]    ROWS_K   = 7'(SCREEN_ROWS);
    localparam logic [10:0]   SIZE_K   = 11'(STORE_SIZE);
    localparam logic [4:0]    RB_K     = 5'(ROW_BYTES);
    localparam logic [CW-1:0] COL_LAST = CW'(ROW_BYTES - 1);
    localparam logic [AW-1:0] IDX_LAST = AW'(STORE_SIZE - 1);

    // Sequencer states.
    localparam logic [3:0] ST_WIPE  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_REM   = 4'd3;
    localparam logic [3:0] ST_IDX   = 4'd4;
    localparam logic [3:0] ST_RD0   = 4'd5;
    localparam logic [3:0] ST_WR0   = 4'd6;
    localparam logic [3:0] ST_RD1   = 4'd7;
    localparam logic [3:0] ST_WR1   = 4'd8;
    localparam logic [3:0] ST_REPLY = 4'd9;

    // Control state.
    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] wipe_cnt_reg, wipe_cnt_next;
    logic          wipe_reply_reg, wipe_reply_next;
    logic          collision_reg, collision_next;
    logic          redraw_reg, redraw_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // Payload of the beat in work and its intermediate results.
    sxfb_pkg::op_t op_reg, op_next;
    logic [7:0]    x_reg, x_next;
    logic [8:0]    sum_reg, sum_next;
    logic [7:0]    bits_reg, bits_next;
    logic [7:0]    addr_reg, addr_next;
    logic [7:0]    qx_reg, qx_next;
    logic [8:0]    qy_reg, qy_next;
    logic [7:0]    qa_reg, qa_next;
    logic [PXW-1:0] px_reg, px_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] adr_reg, adr_next;
    logic [AW-1:0] idx0_reg, idx0_next;
    logic [AW-1:0] idx1_reg, idx1_next;
    logic [7:0]    data_reg, data_next;
    logic [sxfb_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Frame memory ports.
    logic [7:0]    frame_mem [STORE_SIZE];
    logic [7:0]    mem_rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_wdata;

    // Arithmetic nets.
    logic [24:0]   mul_x;
    logic [26:0]   mul_y;
    logic [26:0]   mul_a;
    logic [15:0]   px_full;
    logic [15:0]   row_full;
    logic [18:0]   adr_full;
    logic [CW-1:0] col0;
    logic [CW-1:0] col1;
    logic [BW-1:0] row_base;
    logic [15:0]   sprite_shift;
    logic [7:0]    first_bits;
    logic [7:0]    second_bits;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Quotients by reciprocal multiplication, then remainders.
    assign mul_x    = 25'(x_reg) * 25'(RECIP_X);
    assign mul_y    = 27'(sum_reg) * 27'(RECIP_Y);
    assign mul_a    = 27'(addr_reg) * 27'(RECIP_A);
    assign px_full  = 16'(x_reg) - 16'(qx_reg) * 16'(WIDTH_K);
    assign row_full = 16'(sum_reg) - 16'(qy_reg) * 16'(ROWS_K);
    assign adr_full = 19'(addr_reg) - 19'(qa_reg) * 19'(SIZE_K);

    // Column bytes touched by the sprite; the second wraps within the row.
    assign col0     = px_reg[PXW-1:3];
    assign col1     = (col0 == COL_LAST) ? '0 : col0 + CW'(1);
    assign row_base = BW'(row_reg) * BW'(RB_K);

    // The sprite byte split over the two store bytes by the pixel offset.
    assign sprite_shift = {bits_reg, 8'h00} >> px_reg[2:0];
    assign first_bits   = sprite_shift[15:8];
    assign second_bits  = sprite_shift[7:0];

    always_comb begin
        state_next      = state_reg;
        wipe_cnt_next   = wipe_cnt_reg;
        wipe_reply_next = wipe_reply_reg;
        collision_next  = collision_reg;
        redraw_next     = redraw_reg;
        m_tvalid_next   = m_tvalid_reg;
        op_next         = op_reg;
        x_next          = x_reg;
        sum_next        = sum_reg;
        bits_next       = bits_reg;
        addr_next       = addr_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        qa_next         = qa_reg;
        px_next         = px_reg;
        row_next        = row_reg;
        adr_next        = adr_reg;
        idx0_next       = idx0_reg;
        idx1_next       = idx1_reg;
        data_next       = data_reg;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx0_reg;
        mem_wdata       = 8'h00;
        mem_raddr       = idx0_reg;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_WIPE: begin
                mem_we    = 1'b1;
                mem_waddr = wipe_cnt_reg;
                mem_wdata = 8'h00;
                if (wipe_cnt_reg == IDX_LAST) begin
                    wipe_cnt_next   = '0;
                    wipe_reply_next = 1'b0;
                    state_next      = wipe_reply_reg ? ST_REPLY : ST_IDLE;
                end else begin
                    wipe_cnt_next = wipe_cnt_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next   = s_tuser;
                    x_next    = s_tdata[7:0];
                    sum_next  = 9'(s_tdata[15:8]) + 9'(s_tdata[19:16]);
                    bits_next = s_tdata[27:20];
                    addr_next = s_tdata[35:28];
                    data_next = 8'h00;
                    unique case (s_tuser)
                        sxfb_pkg::OP_CLEAR: begin
                            redraw_next     = 1'b1;
                            wipe_cnt_next   = '0;
                            wipe_reply_next = 1'b1;
                            state_next      = ST_WIPE;
                        end
                        sxfb_pkg::OP_DRAW: begin
                            redraw_next = 1'b1;
                            if (s_tdata[19:16] == 4'd0) begin
                                collision_next = 1'b0;
                            end
                            state_next = ST_DIV;
                        end
                        sxfb_pkg::OP_READ: begin
                            state_next = ST_DIV;
                        end
                        sxfb_pkg::OP_ACK: begin
                            redraw_next = 1'b0;
                            state_next  = ST_REPLY;
                        end
                        default: begin
                            state_next = ST_REPLY;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                qx_next    = mul_x[23:16];
                qy_next    = mul_y[25:17];
                qa_next    = mul_a[25:18];
                state_next = ST_REM;
            end
            ST_REM: begin
                px_next    = px_full[PXW-1:0];
                row_next   = row_full[RW-1:0];
                adr_next   = adr_full[AW-1:0];
                state_next = ST_IDX;
            end
            ST_IDX: begin
                if (op_reg == sxfb_pkg::OP_READ) begin
                    idx0_next = adr_reg;
                end else begin
                    idx0_next = AW'(row_base + BW'(col0));
                end
                idx1_next  = AW'(row_base + BW'(col1));
                state_next = ST_RD0;
            end
            ST_RD0: begin
                mem_raddr  = idx0_reg;
                state_next = ST_WR0;
            end
            ST_WR0: begin
                if (op_reg == sxfb_pkg::OP_READ) begin
                    data_next  = mem_rdata_reg;
                    state_next = ST_REPLY;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = idx0_reg;
                    mem_wdata = mem_rdata_reg ^ first_bits;
                    if ((mem_rdata_reg & first_bits) != 8'h00) begin
                        collision_next = 1'b1;
                    end
                    state_next = ST_RD1;
                end
            end
            ST_RD1: begin
                // The first write landed at the last edge, so this read sees it
                // even when both bytes are the same entry.
                mem_raddr  = idx1_reg;
                state_next = ST_WR1;
            end
            ST_WR1: begin
                mem_we    = 1'b1;
                mem_waddr = idx1_reg;
                mem_wdata = mem_rdata_reg ^ second_bits;
                if ((mem_rdata_reg & second_bits) != 8'h00) begin
                    collision_next = 1'b1;
                end
                state_next = ST_REPLY;
            end
            ST_REPLY: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, redraw_reg, collision_reg, data_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Frame memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= frame_mem[mem_raddr];
    end

    // Control state; reset starts the clearing pass over the store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_WIPE;
            wipe_cnt_reg   <= '0;
            wipe_reply_reg <= 1'b0;
            collision_reg  <= 1'b0;
            redraw_reg     <= 1'b1;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wipe_cnt_reg   <= wipe_cnt_next;
            wipe_reply_reg <= wipe_reply_next;
            collision_reg  <= collision_next;
            redraw_reg     <= redraw_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        x_reg       <= x_next;
        sum_reg     <= sum_next;
        bits_reg    <= bits_next;
        addr_reg    <= addr_next;
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        qa_reg      <= qa_next;
        px_reg      <= px_next;
        row_reg     <= row_next;
        adr_reg     <= adr_next;
        idx0_reg    <= idx0_next;
        idx1_reg    <= idx1_next;
        data_reg    <= data_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// File: src/sxfb_checker.sv
// Port-level checker for the sprite frame store, bound to the top level.
`include "sprite_xor_framebuffer_assert.svh"

module sxfb_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sxfb_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result beat holds.
    `SXFB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Every operation leaves the block busy, with s_tready low, once it is taken.
    `SXFB_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)

    // The block stays ready while no beat is offered.
    `SXFB_ASSERT_NEXT(a_idle_holds, s_tready && !s_tvalid, s_tready)

    // A result is loaded only from the reply step, never while the input side is open.
    `SXFB_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), !$past(s_tready))

endmodule

bind sprite_xor_framebuffer sxfb_checker u_sxfb_checker (.*);
